>>> rtl/bfh_pkg.sv
package bfh_pkg;

  typedef struct packed {
    logic              req_type;
    logic [7:0]        col;
    logic [7:0]        row;
    logic signed [31:0] entry_value;
    logic [7:0]        box_size;
  } bfh_in_t;

  typedef struct packed {
    logic signed [31:0] dxx;
    logic signed [31:0] dyy;
    logic signed [31:0] dxy;
    logic               out_of_range;
  } bfh_out_t;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam int NUM_READS = 40;
  localparam int SUM_W     = 40;
  localparam int DIV_W     = 48;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_DIV,
    ST_DONE
  } bfh_state_t;

  localparam logic [1:0] REG_COLS = 2'd0;
  localparam logic [1:0] REG_ROWS = 2'd1;

endpackage

>>> rtl/bfh_ram.sv
module bfh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/bfh_div.sv
// Restoring signed divider, one quotient bit per cycle, saturating to 32 bits.
module bfh_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    go,
  input  logic signed [bfh_pkg::DIV_W-1:0] num,
  input  logic [15:0]             den,
  output logic                    done,
  output logic signed [31:0]      quo
);
  import bfh_pkg::*;

  logic [DIV_W-1:0] q_r, q_nxt;
  logic [16:0]      rem_r, rem_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             neg_r, neg_nxt;
  logic             done_r, done_nxt;
  logic [16:0]      trial;
  logic [DIV_W:0]   sq;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    trial    = {rem_r[15:0], q_r[DIV_W-1]};
    if (go) begin
      neg_nxt = num[DIV_W-1];
      q_nxt   = num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);
      rem_nxt = '0;
      cnt_nxt = 6'(DIV_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, den}) begin
        rem_nxt = trial - {1'b0, den};
        q_nxt   = {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  // magnitude fits DIV_W bits; saturate signed
  always_comb begin
    sq = neg_r ? -{1'b0, q_r} : {1'b0, q_r};
    if (!neg_r && q_r > DIV_W'(32'h7fffffff)) begin
      quo = 32'sh7fffffff;
    end else if (neg_r && q_r > DIV_W'(33'h80000000)) begin
      quo = 32'sh80000000;
    end else begin
      quo = sq[31:0];
    end
  end

  assign done = done_r;
endmodule

>>> rtl/bfh_corner.sv
// Corner generator: for read step k gives coordinates, weight and derivative.
module bfh_corner (
  input  logic [5:0]        step,
  input  logic [7:0]        cx,
  input  logic [7:0]        cy,
  input  logic [6:0]        lobe,
  input  logic [5:0]        half,
  output logic signed [10:0] px,
  output logic signed [10:0] py,
  output logic signed [2:0]  wt,
  output logic [1:0]         sel
);
  import bfh_pkg::*;

  logic signed [10:0] x, y, l, h;
  logic signed [10:0] ax0, ay0, ax1, ay1;
  logic signed [2:0]  bw;
  logic [3:0]         box;
  logic [1:0]         cn;

  always_comb begin
    x   = 11'(cx);
    y   = 11'(cy);
    l   = 11'(lobe);
    h   = 11'(half);
    box = step[5:2];
    cn  = step[1:0];
    ax0 = '0; ay0 = '0; ax1 = '0; ay1 = '0; bw = 3'sd1; sel = 2'd0;
    case (box)
      4'd0: begin ax0 = x-l-h;   ay0 = y-l+1; ax1 = x-h;     ay1 = y+l; bw = 3'sd1; end
      4'd1: begin ax0 = x-h;     ay0 = y-l+1; ax1 = x+h+1;   ay1 = y+l; bw = -3'sd2; end
      4'd2: begin ax0 = x+h+1;   ay0 = y-l+1; ax1 = x+h+l+1; ay1 = y+l; bw = 3'sd1; end
      4'd3: begin ax0 = x-l+1; ay0 = y-l-h;   ax1 = x+l; ay1 = y-h;     bw = 3'sd1; sel = 2'd1; end
      4'd4: begin ax0 = x-l+1; ay0 = y-h;     ax1 = x+l; ay1 = y+h+1;   bw = -3'sd2; sel = 2'd1; end
      4'd5: begin ax0 = x-l+1; ay0 = y+h+1;   ax1 = x+l; ay1 = y+h+l+1; bw = 3'sd1; sel = 2'd1; end
      4'd6: begin ax0 = x-l; ay0 = y-l; ax1 = x;     ay1 = y;     bw = 3'sd1; sel = 2'd2; end
      4'd7: begin ax0 = x+1; ay0 = y-l; ax1 = x+l+1; ay1 = y;     bw = -3'sd1; sel = 2'd2; end
      4'd8: begin ax0 = x-l; ay0 = y+1; ax1 = x;     ay1 = y+l+1; bw = -3'sd1; sel = 2'd2; end
      default: begin ax0 = x+1; ay0 = y+1; ax1 = x+1+l; ay1 = y+1+l; bw = 3'sd1; sel = 2'd2; end
    endcase
    case (cn)
      2'd0:    begin px = ax0; py = ay0; wt = bw; end
      2'd1:    begin px = ax1; py = ay1; wt = bw; end
      2'd2:    begin px = ax0; py = ay1; wt = -bw; end
      default: begin px = ax1; py = ay0; wt = -bw; end
    endcase
  end
endmodule

>>> rtl/box_filter_hessian_core.sv
// Box-filter Hessian core over an integral image in one single-port-read RAM.
// Write item: accepted, busy stays low, no result.
// Query item: 40 corner reads (one per cycle), a drain state, then three serial
// divides (48 quotient bits each, the next loaded as the previous one completes);
// out_valid strobes in the last busy cycle. Out-of-range query skips the divides.
// Receiver cannot stall. Sync active-low reset clears control and config only.
module box_filter_hessian_core #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  bfh_pkg::bfh_in_t in_item,
  output logic             out_valid,
  output bfh_pkg::bfh_out_t out_item,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import bfh_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int AW = CW + RW;

  // config registers
  logic [8:0] cols_r, rows_r;
  logic [1:0] reg_idx;
  assign reg_idx = paddr[2+:1] == 1'b1 ? REG_ROWS : REG_COLS;
  assign pready  = 1'b1;
  always_comb begin
    unique case (reg_idx)
      REG_COLS: prdata = {23'd0, cols_r};
      default:  prdata = {23'd0, rows_r};
    endcase
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= 9'd256;
      rows_r <= 9'd256;
    end else if (psel && penable && pwrite) begin
      if (reg_idx == REG_COLS) cols_r <= pwdata[8:0];
      else                     rows_r <= pwdata[8:0];
    end
  end

  // effective limits, clamped to store size
  logic [12:0] lim_c, lim_r;
  assign lim_c = (13'(cols_r) < 13'(MAX_COLUMNS)) ? 13'(cols_r) : 13'(MAX_COLUMNS);
  assign lim_r = (13'(rows_r) < 13'(MAX_ROWS))    ? 13'(rows_r) : 13'(MAX_ROWS);

  // query state
  bfh_state_t st_r, st_nxt;
  logic [7:0]  qx_r, qy_r, qs_r;
  logic [6:0]  lobe_r;
  logic [5:0]  half_r;
  logic [5:0]  step_r, step_nxt;
  logic        bad_r;
  logic signed [SUM_W-1:0] acc_r [3];
  logic signed [2:0] pwt_r;
  logic [1:0]  psel_r;
  logic        pvld_r;
  logic [1:0]  dsel_r;
  logic [15:0] den_r;
  logic signed [31:0] res_r [3];
  logic        div_go;
  logic        div_done;
  logic signed [31:0] div_q;

  logic accept;
  assign accept = start && (st_r == ST_IDLE);
  assign busy   = (st_r != ST_IDLE);

  // size/3 by reciprocal: floor(s*171/512) is exact for s below 512
  logic [15:0] third_prod;
  assign third_prod = 16'(in_item.box_size) * 16'd171;

  // corner generation
  logic signed [10:0] px, py;
  logic signed [2:0]  wt;
  logic [1:0]         dsel;
  bfh_corner u_corner (
    .step(step_r), .cx(qx_r), .cy(qy_r), .lobe(lobe_r), .half(half_r),
    .px(px), .py(py), .wt(wt), .sel(dsel)
  );
  logic cbad;
  assign cbad = px[10] || py[10] || (13'(px) >= lim_c) || (13'(py) >= lim_r);

  // RAM
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   rdata;
  assign we    = accept && in_item.req_type == REQ_WRITE
                 && 32'(in_item.col) < 32'(MAX_COLUMNS) && 32'(in_item.row) < 32'(MAX_ROWS);
  assign waddr = {RW'(in_item.row), CW'(in_item.col)};
  assign raddr = {RW'(py), CW'(px)};
  bfh_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(in_item.entry_value),
    .raddr(raddr), .rdata(rdata)
  );

  // weighted entry: weights are +-1 and +-2 only
  logic signed [SUM_W-1:0] ent_ext, acc_term;
  assign ent_ext = SUM_W'(signed'(rdata));
  always_comb begin
    case (pwt_r)
      3'sd1:   acc_term = ent_ext;
      -3'sd1:  acc_term = -ent_ext;
      3'sd2:   acc_term = ent_ext <<< 1;
      default: acc_term = -(ent_ext <<< 1);
    endcase
  end

  // divider operand: the next sum is loaded on the done cycle of the previous one
  logic [1:0]              nsel;
  logic signed [DIV_W-1:0] div_num;
  assign nsel = (st_r == ST_DIV) ? dsel_r + 2'd1 : dsel_r;
  always_comb begin
    case (nsel)
      2'd0:    div_num = DIV_W'(acc_r[0]) <<< 8;
      2'd1:    div_num = DIV_W'(acc_r[1]) <<< 8;
      default: div_num = DIV_W'(acc_r[2]) <<< 8;
    endcase
  end

  bfh_div u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go),
    .num(div_num), .den(den_r), .done(div_done), .quo(div_q)
  );

  // next state
  always_comb begin
    st_nxt   = st_r;
    step_nxt = step_r;
    unique case (st_r)
      ST_IDLE: if (accept && in_item.req_type == REQ_QUERY) begin
        st_nxt = ST_READ; step_nxt = '0;
      end
      ST_READ: begin
        step_nxt = step_r + 6'd1;
        if (step_r == 6'(NUM_READS-1)) st_nxt = ST_DRAIN;
      end
      ST_DRAIN: st_nxt = (bad_r || qs_r == 8'd0) ? ST_DONE : ST_DIV;
      ST_DIV:   if (div_done && dsel_r == 2'd2) st_nxt = ST_DONE;
      ST_DONE:  st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    div_go    = 1'b0;
    out_valid = 1'b0;
    unique case (st_r)
      ST_DRAIN: div_go = !(bad_r || qs_r == 8'd0);
      ST_DIV:   div_go = div_done && dsel_r != 2'd2;
      ST_DONE:  out_valid = 1'b1;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      pvld_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      pvld_r <= (st_r == ST_READ);
    end
    step_r <= step_nxt;
    pwt_r  <= wt;
    psel_r <= dsel;
    if (accept) begin
      qx_r   <= in_item.col;
      qy_r   <= in_item.row;
      qs_r   <= in_item.box_size;
      lobe_r <= third_prod[15:9];
      half_r <= third_prod[15:10];
      den_r  <= 16'(in_item.box_size) * 16'(in_item.box_size);
      bad_r  <= 1'b0;
      for (int i = 0; i < 3; i++) acc_r[i] <= '0;
      dsel_r <= 2'd0;
    end else begin
      if (st_r == ST_READ && cbad) bad_r <= 1'b1;
      if (pvld_r) begin
        acc_r[psel_r] <= acc_r[psel_r] + acc_term;
      end
      if (st_r == ST_DIV && div_done) begin
        res_r[dsel_r] <= div_q;
        dsel_r <= dsel_r + 2'd1;
      end
    end
  end

  always_comb begin
    if (bad_r || qs_r == 8'd0) begin
      out_item = '{dxx: '0, dyy: '0, dxy: '0, out_of_range: 1'b1};
    end else begin
      out_item = '{dxx: res_r[0], dyy: res_r[1], dxy: res_r[2], out_of_range: 1'b0};
    end
  end
endmodule
